FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("never failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

FILE: rtl/czs_pkg.sv
// ---------------------------------------------------------------------------
// Camera zone switch package
// Types and constants shared by the camera zone switch block.
// ---------------------------------------------------------------------------
package czs_pkg;
  localparam int ZoneDepth = 64;
  localparam int SlotW = $clog2(ZoneDepth);

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SETCAM = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_IMMED = 3'd1;
  localparam logic [2:0] ACT_DEFER = 3'd2;
  localparam logic [2:0] ACT_FORCE = 3'd3;
  localparam logic [2:0] ACT_SUPPR = 3'd4;

  localparam logic REG_SWITCH_DISABLED = 1'b0;
  localparam logic REG_DEFER_REDISPLAY = 1'b1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] entry_index;
    logic [31:0] corner_a;
    logic [31:0] corner_b;
    logic [31:0] corner_c;
    logic [31:0] corner_d;
    logic [7:0] from_camera;
    logic [7:0] to_camera;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_z;
    logic force_cut;
  } czs_in_t;

  typedef struct packed {
    logic [2:0] action;
    logic hit;
    logic [5:0] hit_slot;
    logic [7:0] camera_now;
    logic group_missing;
  } czs_out_t;

  // One edge test: (ex*dz) cmp (ez*dx); le selects "<=" else ">="
  typedef struct packed {
    logic signed [17:0] ex;
    logic signed [17:0] ez;
    logic signed [17:0] dx;
    logic signed [17:0] dz;
    logic le;
  } czs_edge_t;
endpackage

FILE: rtl/czs_edge.sv
// ---------------------------------------------------------------------------
// Edge test unit
// Registered cross-product compare, shared over all edge tests.
// ---------------------------------------------------------------------------
module czs_edge (
  input  logic              clk,
  input  czs_pkg::czs_edge_t op,
  output logic              pass_r
);
  import czs_pkg::*;
  logic signed [35:0] p1, p2;
  logic pass_nxt;
  always_comb begin
    p1 = op.ex * op.dz;
    p2 = op.ez * op.dx;
    pass_nxt = op.le ? (p1 <= p2) : (p1 >= p2);
  end
  always_ff @(posedge clk) begin
    pass_r <= pass_nxt;
  end
endmodule

FILE: rtl/camera_zone_switch_unit.sv
// ---------------------------------------------------------------------------
// Camera zone switch unit
// Quadrilateral camera switch zones with group search and point test.
// ---------------------------------------------------------------------------
// channel | direction | handshake
// in_     | in        | start / busy
// out_    | out       | out_valid strobe, one cycle, no stall
// cfg_    | in        | APB write/read, pready always high
//
// Write: a single store, then done. Set camera: a group search that reads
// each slot in a read/check state pair. Query: per scanned zone a read/check
// state pair and edge tests E0 to E3 on the shared multiplier-compare unit,
// plus a group search on an immediate switch. Reset clears valid bits at once.
`include "assert_macros.svh"
module camera_zone_switch_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  czs_pkg::czs_in_t   in_data,
  output logic               out_valid,
  output czs_pkg::czs_out_t  out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import czs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_SCAN_RD, S_SCAN_CHK,
    S_E0, S_E1, S_E2, S_E3, S_EW, S_DONE
  } state_t;

  state_t state_r;
  logic sw_dis_r, defer_r;
  logic [ZoneDepth-1:0] valid_r;
  logic [127:0] corner_mem [ZoneDepth];
  logic [15:0] cam_mem [ZoneDepth];
  logic [127:0] rd_corner_r;
  logic [15:0] rd_cam_r;
  logic [SlotW-1:0] idx_r;
  logic rd_valid_r;
  czs_in_t item_r;
  logic [7:0] cam_r;
  logic [SlotW-1:0] base_r;
  logic found_r;
  logic hit_r;
  logic [SlotW-1:0] hit_slot_r;
  logic [2:0] act_r;
  logic edge_fail_r;
  logic out_valid_r;
  czs_out_t out_r;

  // Config port: write at access phase
  assign cfg_pready = 1'b1;
  wire cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_DEFER_REDISPLAY) cfg_prdata[0] = defer_r;
    else cfg_prdata[0] = sw_dis_r;
  end

  // Zone memory; read data registered
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start && in_data.opcode == OP_WRITE) begin
      corner_mem[in_data.entry_index] <= {in_data.corner_d, in_data.corner_c,
                                          in_data.corner_b, in_data.corner_a};
      cam_mem[in_data.entry_index] <= {in_data.to_camera, in_data.from_camera};
    end
    rd_corner_r <= corner_mem[idx_r];
    rd_cam_r <= cam_mem[idx_r];
  end

  // Edge operand select for the shared unit
  czs_edge_t eop;
  logic edge_pass;
  logic signed [17:0] x0, z0, x1, z1, x2, z2, x3, z3, px, pz;
  always_comb begin
    x0 = {2'b0, rd_corner_r[15:0]};   z0 = {2'b0, rd_corner_r[31:16]};
    x1 = {2'b0, rd_corner_r[47:32]};  z1 = {2'b0, rd_corner_r[63:48]};
    x2 = {2'b0, rd_corner_r[79:64]};  z2 = {2'b0, rd_corner_r[95:80]};
    x3 = {2'b0, rd_corner_r[111:96]}; z3 = {2'b0, rd_corner_r[127:112]};
    px = 18'(item_r.pos_x);
    pz = 18'(item_r.pos_z);
    eop = '0;
    unique case (state_r)
      S_E0: eop = '{ex: x1 - x0, ez: z1 - z0, dx: px - x0, dz: pz - z0, le: 1'b1};
      S_E1: eop = '{ex: x3 - x0, ez: z3 - z0, dx: px - x0, dz: pz - z0, le: 1'b0};
      S_E2: eop = '{ex: x1 - x2, ez: z1 - z2, dx: px - x2, dz: pz - z2, le: 1'b0};
      S_E3: eop = '{ex: x3 - x2, ez: z3 - z2, dx: px - x2, dz: pz - z2, le: 1'b1};
      default: eop = '0;
    endcase
  end

  czs_edge u_edge (.clk(clk), .op(eop), .pass_r(edge_pass));

  wire last_idx = (idx_r == SlotW'(ZoneDepth - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sw_dis_r <= 1'b0;
      defer_r <= 1'b0;
      valid_r <= '0;
      cam_r <= '0;
      base_r <= '0;
      found_r <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r <= '0;
      edge_fail_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_wr) begin
        if (cfg_paddr[2] == REG_DEFER_REDISPLAY) defer_r <= cfg_pwdata[0];
        else sw_dis_r <= cfg_pwdata[0];
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            item_r <= in_data;
            hit_r <= 1'b0;
            hit_slot_r <= '0;
            act_r <= ACT_NONE;
            unique case (in_data.opcode)
              OP_WRITE: begin
                valid_r[in_data.entry_index] <= 1'b1;
                state_r <= S_DONE;
              end
              OP_SETCAM: begin
                cam_r <= in_data.to_camera;
                idx_r <= '0;
                state_r <= S_SRCH_RD;
              end
              OP_QUERY: begin
                if (sw_dis_r) begin
                  act_r <= ACT_SUPPR;
                  state_r <= S_DONE;
                end else if (!found_r || base_r == SlotW'(ZoneDepth - 1)) begin
                  if (in_data.force_cut) act_r <= ACT_FORCE;
                  state_r <= S_DONE;
                end else begin
                  idx_r <= base_r + 1'b1;
                  state_r <= S_SCAN_RD;
                end
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_SRCH_RD: begin
          rd_valid_r <= valid_r[idx_r];
          state_r <= S_SRCH_CHK;
        end
        S_SRCH_CHK: begin
          if (rd_valid_r && rd_cam_r[7:0] == cam_r) begin
            base_r <= idx_r;
            found_r <= 1'b1;
            state_r <= S_DONE;
          end else if (last_idx) begin
            found_r <= 1'b0;
            state_r <= S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
            state_r <= S_SRCH_RD;
          end
        end
        S_SCAN_RD: begin
          rd_valid_r <= valid_r[idx_r];
          state_r <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (!rd_valid_r || rd_cam_r[7:0] != cam_r) begin
            if (item_r.force_cut) act_r <= ACT_FORCE;
            state_r <= S_DONE;
          end else begin
            edge_fail_r <= 1'b0;
            state_r <= S_E0;
          end
        end
        S_E0: state_r <= S_E1;
        S_E1: begin
          edge_fail_r <= edge_fail_r | ~edge_pass;
          state_r <= S_E2;
        end
        S_E2: begin
          edge_fail_r <= edge_fail_r | ~edge_pass;
          state_r <= S_E3;
        end
        S_E3: begin
          edge_fail_r <= edge_fail_r | ~edge_pass;
          state_r <= S_EW;
        end
        S_EW: begin
          // Advance on a miss, switch on a hit
          if (!(edge_fail_r | ~edge_pass)) begin
            hit_r <= 1'b1;
            hit_slot_r <= idx_r;
            cam_r <= rd_cam_r[15:8];
            if (defer_r) begin
              act_r <= ACT_DEFER;
              state_r <= S_DONE;
            end else begin
              act_r <= ACT_IMMED;
              idx_r <= '0;
              state_r <= S_SRCH_RD;
            end
          end else if (last_idx) begin
            if (item_r.force_cut) act_r <= ACT_FORCE;
            state_r <= S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
            state_r <= S_SCAN_RD;
          end
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    out_r.action = act_r;
    out_r.hit = hit_r;
    out_r.hit_slot = hit_slot_r;
    out_r.camera_now = cam_r;
    out_r.group_missing = ~found_r;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE) out_data <= out_r;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // A hit always comes with a switch action
  wire hit_act_ok = (out_data.action == ACT_IMMED) || (out_data.action == ACT_DEFER);

  `ASSERT_CLK(a_done_strobe, clk, rst_n, (state_r == S_DONE) |=> out_valid)
  `ASSERT_CLK(a_start_busy, clk, rst_n, (start && !busy) |=> busy)
  `ASSERT_NEVER(a_hit_act, clk, rst_n, out_valid && out_data.hit && !hit_act_ok)
endmodule

FILE: dv/czs_checker.sv
// ---------------------------------------------------------------------------
// Camera zone switch checker
// Watches the command, result and register ports of the zone switch unit,
// keeps a shadow zone table, predicts every result and compares it.
// ---------------------------------------------------------------------------
module czs_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  czs_pkg::czs_in_t  in_data,
  input  logic              out_valid,
  input  czs_pkg::czs_out_t out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic              cfg_pready,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output int                fail_count,
  output int                outcomes_pending
);
  import czs_pkg::*;

  logic            zv [ZoneDepth];
  logic [31:0]     zc [ZoneDepth][4];
  logic [7:0]      zfrom [ZoneDepth];
  logic [7:0]      zto [ZoneDepth];
  logic [7:0]      cam;
  int              gbase;
  logic            gfound;
  logic            sw_dis;
  logic            defer;
  czs_out_t        outcome_q [$];

  assign outcomes_pending = outcome_q.size();

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    $display("mismatch %s: expected %0d got %0d", what, exp_v, got_v);
    fail_count++;
  endtask

  function automatic longint cx(input logic [31:0] c);
    return longint'({48'd0, c[15:0]});
  endfunction

  function automatic longint cz(input logic [31:0] c);
    return longint'({48'd0, c[31:16]});
  endfunction

  function automatic logic zone_contains(input int s, input longint px, input longint pz);
    longint x0, z0, x2, z2, dx, dz;
    x0 = cx(zc[s][0]); z0 = cz(zc[s][0]);
    x2 = cx(zc[s][2]); z2 = cz(zc[s][2]);
    dx = px - x0; dz = pz - z0;
    if ((cx(zc[s][1]) - x0) * dz > (cz(zc[s][1]) - z0) * dx) return 1'b0;
    if ((cx(zc[s][3]) - x0) * dz < (cz(zc[s][3]) - z0) * dx) return 1'b0;
    dx = px - x2; dz = pz - z2;
    if ((cx(zc[s][1]) - x2) * dz < (cz(zc[s][1]) - z2) * dx) return 1'b0;
    if ((cx(zc[s][3]) - x2) * dz > (cz(zc[s][3]) - z2) * dx) return 1'b0;
    return 1'b1;
  endfunction

  task automatic locate_group();
    gfound = 1'b0;
    for (int i = 0; i < ZoneDepth; i++) begin
      if (zv[i] && zfrom[i] == cam) begin
        gbase = i;
        gfound = 1'b1;
        break;
      end
    end
  endtask

  task automatic predict_outcome(input czs_in_t it);
    czs_out_t o;
    longint px, pz;
    o = '0;
    case (it.opcode)
      OP_WRITE: begin
        zv[it.entry_index] = 1'b1;
        zc[it.entry_index][0] = it.corner_a;
        zc[it.entry_index][1] = it.corner_b;
        zc[it.entry_index][2] = it.corner_c;
        zc[it.entry_index][3] = it.corner_d;
        zfrom[it.entry_index] = it.from_camera;
        zto[it.entry_index] = it.to_camera;
      end
      OP_SETCAM: begin
        cam = it.to_camera;
        locate_group();
      end
      OP_QUERY: begin
        if (sw_dis) begin
          o.action = ACT_SUPPR;
        end else begin
          px = longint'(it.pos_x);
          pz = longint'(it.pos_z);
          if (gfound) begin
            for (int i = gbase + 1; i < ZoneDepth; i++) begin
              if (!zv[i] || zfrom[i] != cam) break;
              if (zone_contains(i, px, pz)) begin
                o.hit = 1'b1;
                o.hit_slot = i[5:0];
                cam = zto[i];
                if (defer) begin
                  o.action = ACT_DEFER;
                end else begin
                  o.action = ACT_IMMED;
                  locate_group();
                end
                break;
              end
            end
          end
          if (!o.hit && it.force_cut) o.action = ACT_FORCE;
        end
      end
      default: ;
    endcase
    o.camera_now = cam;
    o.group_missing = !gfound;
    outcome_q.push_back(o);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ZoneDepth; i++) zv[i] = 1'b0;
      cam = '0;
      gbase = 0;
      gfound = 1'b0;
      sw_dis = 1'b0;
      defer = 1'b0;
      outcome_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == 3'(REG_SWITCH_DISABLED) * 3'd4) sw_dis = cfg_pwdata[0];
        if (cfg_paddr == 3'(REG_DEFER_REDISPLAY) * 3'd4) defer = cfg_pwdata[0];
      end
      if (out_valid) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("unexpected result", 0, 1);
        end else begin
          czs_out_t e;
          e = outcome_q.pop_front();
          if (out_data.action !== e.action)
            report_mismatch("action", e.action, out_data.action);
          if (out_data.hit !== e.hit) report_mismatch("hit", e.hit, out_data.hit);
          if (out_data.hit_slot !== e.hit_slot)
            report_mismatch("hit_slot", e.hit_slot, out_data.hit_slot);
          if (out_data.camera_now !== e.camera_now)
            report_mismatch("camera_now", e.camera_now, out_data.camera_now);
          if (out_data.group_missing !== e.group_missing)
            report_mismatch("group_missing", e.group_missing, out_data.group_missing);
        end
      end
      // Predict after the compare so a same-edge result never sees its own item
      if (start && !busy) predict_outcome(in_data);
    end
  end

endmodule

FILE: dv/camera_zone_switch_unit_tb.sv
// ---------------------------------------------------------------------------
// Camera zone switch unit testbench
// Drives zone writes, camera sets, position queries and random noise items
// through the command port under several register settings and idle patterns;
// a checker module predicts and compares every result.
// ---------------------------------------------------------------------------
module camera_zone_switch_unit_tb;
  import czs_pkg::*;

  localparam logic [2:0] ADDR_SW_DIS = 3'(REG_SWITCH_DISABLED) * 3'd4;
  localparam logic [2:0] ADDR_DEFER  = 3'(REG_DEFER_REDISPLAY) * 3'd4;
  localparam int CYCLE_LIMIT = 6000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  czs_in_t     in_data = '0;
  logic        out_valid;
  czs_out_t    out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count;
  int          outcomes_pending;
  int          idle_pct = 0;
  int          cycle_count = 0;

  always #5 clk = ~clk;

  camera_zone_switch_unit u_dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  czs_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready, .cfg_paddr, .cfg_pwdata,
    .fail_count, .outcomes_pending
  );

  // Bound the run; a hung handshake ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Hand one command over; start stays high on return so a back-to-back
  // transfer needs no second assignment in the same step.
  task automatic issue(input czs_in_t it);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      while ($urandom_range(99) < idle_pct) @(posedge clk);
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drain all results, then hold a little before touching registers
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (outcomes_pending != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic dis, input logic dfr);
    settle();
    reg_write(ADDR_SW_DIS, {31'd0, dis});
    reg_write(ADDR_DEFER, {31'd0, dfr});
  endtask

  function automatic czs_in_t rand_item();
    czs_in_t it;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(czs_in_t)-1:0];
    return it;
  endfunction

  // Corner order that the edge tests accept as inside: top-left,
  // top-right, bottom-right, bottom-left (z grows toward top).
  function automatic czs_in_t rect_zone(input logic [5:0] slot, input logic [7:0] from_cam,
                                        input logic [7:0] to_cam, input logic [15:0] xl,
                                        input logic [15:0] xh, input logic [15:0] zl,
                                        input logic [15:0] zh);
    czs_in_t it;
    it = rand_item();
    it.opcode = OP_WRITE;
    it.entry_index = slot;
    it.corner_a = {zh, xl};
    it.corner_b = {zh, xh};
    it.corner_c = {zl, xh};
    it.corner_d = {zl, xl};
    it.from_camera = from_cam;
    it.to_camera = to_cam;
    return it;
  endfunction

  function automatic czs_in_t cam_cmd(input logic [7:0] c);
    czs_in_t it;
    it = rand_item();
    it.opcode = OP_SETCAM;
    it.to_camera = c;
    return it;
  endfunction

  function automatic czs_in_t query(input logic [15:0] x, input logic [15:0] z,
                                    input logic fc);
    czs_in_t it;
    it = rand_item();
    it.opcode = OP_QUERY;
    it.pos_x = x;
    it.pos_z = z;
    it.force_cut = fc;
    return it;
  endfunction

  // Load a group header plus a run of rectangles, point the camera at it,
  // then query mostly inside the rectangles.
  task automatic run_group(output int n_items);
    int base, len, nq, k;
    logic [7:0] c;
    logic [15:0] xl, zl, w, h;
    logic [15:0] qx [6];
    logic [15:0] qz [6];
    base = $urandom_range(62);
    len = $urandom_range(1, 5);
    if (base + len > 63) len = 63 - base;
    c = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(7));
    issue(rect_zone(6'(base), c, 8'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom)));
    n_items = 1;
    for (int i = 1; i <= len; i++) begin
      xl = 16'($urandom_range(32000));
      zl = 16'($urandom_range(32000));
      w = 16'($urandom_range(1, 700));
      h = 16'($urandom_range(1, 700));
      qx[i] = xl + 16'($urandom_range(w));
      qz[i] = zl + 16'($urandom_range(h));
      issue(rect_zone(6'(base + i), c, ($urandom_range(3) == 0) ? c : 8'($urandom_range(7)),
                      xl, xl + w, zl, zl + h));
      n_items++;
    end
    issue(cam_cmd(c));
    n_items++;
    nq = $urandom_range(1, 6);
    for (int q = 0; q < nq; q++) begin
      k = $urandom_range(1, len);
      if ($urandom_range(3) == 0) issue(query(16'($urandom), 16'($urandom), 1'($urandom)));
      else issue(query(qx[k], qz[k], 1'($urandom)));
      n_items++;
    end
  endtask

  task automatic run_phase(input int pct, input int goal);
    int done, n;
    idle_pct = pct;
    done = 0;
    while (done < goal) begin
      if ($urandom_range(9) < 2) begin
        // noise: any field pattern, including the ignored opcode
        issue(rand_item());
        done++;
      end else begin
        run_group(n);
        done += n;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: missing group, forced cut, group build, hit, miss, extremes
    issue(query(16'h8000, 16'h7fff, 1'b0));
    issue(query(16'h0000, 16'h0000, 1'b1));
    issue(rect_zone(6'd0, 8'd5, 8'd9, 16'd0, 16'd0, 16'd0, 16'd0));
    issue(rect_zone(6'd1, 8'd5, 8'd7, 16'd100, 16'd200, 16'd100, 16'd200));
    issue(rect_zone(6'd2, 8'd5, 8'd6, 16'd0, 16'hffff, 16'd0, 16'hffff));
    issue(rect_zone(6'd4, 8'd7, 8'd5, 16'd0, 16'd50, 16'd0, 16'd50));
    issue(rect_zone(6'd5, 8'd7, 8'd5, 16'd0, 16'd50, 16'd0, 16'd50));
    issue(rect_zone(6'd63, 8'd255, 8'd0, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    issue(cam_cmd(8'd5));
    issue(query(16'd150, 16'd150, 1'b0));
    issue(query(16'd25, 16'd25, 1'b0));
    issue(cam_cmd(8'd5));
    issue(query(16'h7fff, 16'h7fff, 1'b0));
    issue(query(16'h8000, 16'h8000, 1'b1));
    issue(cam_cmd(8'd200));
    issue(query(16'd10, 16'd10, 1'b1));
    begin
      czs_in_t junk;
      junk = rand_item();
      junk.opcode = OP_IGNORED;
      issue(junk);
    end
    issue(cam_cmd(8'd5));
    set_regs(1'b1, 1'b0);
    issue(query(16'd150, 16'd150, 1'b1));
    set_regs(1'b0, 1'b1);
    issue(query(16'd150, 16'd150, 1'b0));
    issue(query(16'd25, 16'd25, 1'b1));

    // Random: register settings crossed with idle patterns
    set_regs(1'b0, 1'b0);
    run_phase(0, 300);
    run_phase(81, 250);
    set_regs(1'b0, 1'b1);
    run_phase(0, 200);
    run_phase(20, 200);
    set_regs(1'b1, 1'b0);
    run_phase(20, 100);
    set_regs(1'b1, 1'b1);
    run_phase(81, 80);
    set_regs(1'b0, 1'b0);
    run_phase(20, 250);
    run_phase(0, 120);

    settle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/czs_pkg.sv
rtl/czs_edge.sv
rtl/camera_zone_switch_unit.sv
dv/czs_checker.sv
dv/camera_zone_switch_unit_tb.sv
